// File: hdl/pfa_pkg.sv
// Shared definitions for the partition fit allocator.
// Holds default sizes, field widths, policy and register codes, and control structs.
// No dependencies.
package pfa_pkg;

  // Default sizing of the free-space table.
  localparam int NUM_PARTITIONS_DEF = 16;
  localparam int SIZE_BITS_DEF      = 16;

  // Fixed widths of the stream and configuration fields.
  localparam int IN_IDX_W   = 4;
  localparam int IN_SIZE_W  = 16;
  localparam int TDATA_W    = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int POL_W      = 2;
  localparam int COUNT_W    = 5;

  // Item kinds carried on in_tuser.
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PART_USED  = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [COUNT_W-1:0] PART_USED_RST = 5'd16;

  // Allocation policies. The last code refuses every request.
  typedef enum logic [POL_W-1:0] {
    POL_FIRST = 2'd0,
    POL_WORST = 2'd1,
    POL_BEST  = 2'd2,
    POL_NONE  = 2'd3
  } policy_t;

  // Control from the sequencer to the shared compare unit.
  typedef struct packed {
    logic    clear;
    logic    en;
    policy_t policy;
  } sel_ctrl_t;

endpackage

// File: hdl/partition_fit_allocator.sv
// Top level of the partition fit allocator: sequencer, valid bits, table RAM, result register.
// Depends on pfa_pkg, pfa_ram and pfa_select.
//
// Channel | Direction | Transaction
// in_     | slave     | tuser: mode; tdata: partition_index[3:0], size_value[19:4]
// out_    | master    | tuser: allocated; tdata: granted_index[3:0], remaining_free[19:4]
// cfg_    | slave     | cfg_index selects fit_policy (0) or partitions_in_use (1)
//
// A load is written to the table as it is taken and the input stays ready. A request is taken,
// then N reads of the table (N partitions in use) go through the single RAM read port into the
// shared compare unit, a decide step finishes the last compare, and a write-back step follows.
// A refused request with no partitions or the refuse-all policy skips to write-back. Reset is
// synchronous and clears the valid bits, so every entry reads as zero with no clearing pass.
// A stalled output holds the block in its write-back step until the result register frees up.
module partition_fit_allocator #(
  parameter int NUM_PARTITIONS = pfa_pkg::NUM_PARTITIONS_DEF,
  parameter int SIZE_BITS      = pfa_pkg::SIZE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [pfa_pkg::TDATA_W-1:0]     in_tdata,   // [3:0] partition_index, [19:4] size_value
  input  logic                            in_tuser,   // [0] mode
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pfa_pkg::TDATA_W-1:0]     out_tdata,  // [3:0] granted_index, [19:4] remaining_free
  output logic                            out_tuser,  // [0] allocated
  // Configuration writes.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfa_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
  localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_WRITE  = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  pfa_pkg::policy_t              policy_r;
  logic [pfa_pkg::COUNT_W-1:0]   count_r;
  logic [CNT_W-1:0]              n_act;
  logic [SIZE_BITS-1:0]          want_r, want_nxt;
  logic [CNT_W-1:0]              scan_r, scan_nxt, scan_inc;
  logic                          rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]              rd_idx_r;
  logic                          rd_vld_r;
  logic [NUM_PARTITIONS-1:0]     vld_r;
  logic                          out_vld_r, out_vld_nxt;
  logic                          out_alloc_r;
  logic [pfa_pkg::IN_IDX_W-1:0]  out_idx_r;
  logic [pfa_pkg::IN_SIZE_W-1:0] out_rem_r;

  logic                          in_acc, is_req, ld_ok, out_free, out_load, wr_grant;
  logic [pfa_pkg::IN_IDX_W-1:0]  in_pidx;
  logic [pfa_pkg::IN_SIZE_W-1:0] in_size;
  logic [IDX_W-1:0]              rd_addr;
  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [SIZE_BITS-1:0]          ram_wdata, ram_q, rd_val, rem;
  pfa_pkg::sel_ctrl_t            sel_ctrl;
  logic                          found;
  logic [IDX_W-1:0]              sel_idx;
  logic [SIZE_BITS-1:0]          sel_val;

  // Field unpacking and handshakes.
  assign in_pidx   = in_tdata[3:0];
  assign in_size   = in_tdata[19:4];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign is_req    = (in_tuser == pfa_pkg::MODE_REQUEST);
  assign ld_ok     = in_acc && (in_tuser == pfa_pkg::MODE_LOAD) &&
                     (32'(in_pidx) < 32'(NUM_PARTITIONS));
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= pfa_pkg::POL_FIRST;
      count_r  <= pfa_pkg::PART_USED_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == pfa_pkg::REG_FIT_POLICY) begin
        policy_r <= pfa_pkg::policy_t'(cfg_data[pfa_pkg::POL_W-1:0]);
      end else if (cfg_index == pfa_pkg::REG_PART_USED) begin
        count_r <= cfg_data;
      end
    end
  end

  // Entry count saturates at the table depth.
  always_comb begin
    if (32'(count_r) > 32'(NUM_PARTITIONS)) begin
      n_act = CNT_W'(NUM_PARTITIONS);
    end else begin
      n_act = CNT_W'(count_r);
    end
  end

  // Table RAM: loads and grant write-backs share the write port.
  assign rem       = sel_val - want_r;
  assign out_free  = !out_vld_r || out_tready;
  assign out_load  = (state_r == ST_WRITE) && out_free;
  assign wr_grant  = out_load && found;
  assign ram_we    = ld_ok || wr_grant;
  assign ram_waddr = ld_ok ? IDX_W'(in_pidx) : sel_idx;
  assign ram_wdata = ld_ok ? SIZE_BITS'(in_size) : rem;
  assign rd_addr   = scan_r[IDX_W-1:0];

  pfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_PARTITIONS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // An entry never written since reset reads as empty.
  assign rd_val = rd_vld_r ? ram_q : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ram_we) begin
      vld_r[ram_waddr] <= 1'b1;
    end
  end

  // Shared compare unit.
  assign sel_ctrl.clear  = in_acc;
  assign sel_ctrl.en     = rd_pend_r;
  assign sel_ctrl.policy = policy_r;

  pfa_select #(
    .IDX_W     (IDX_W),
    .SIZE_BITS (SIZE_BITS)
  ) u_select (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (sel_ctrl),
    .want    (want_r),
    .rd_val  (rd_val),
    .rd_idx  (rd_idx_r),
    .found   (found),
    .sel_idx (sel_idx),
    .sel_val (sel_val)
  );

  // Sequencer.
  assign scan_inc = scan_r + CNT_W'(1);

  always_comb begin
    state_nxt   = state_r;
    want_nxt    = want_r;
    scan_nxt    = scan_r;
    rd_pend_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && is_req) begin
          want_nxt = SIZE_BITS'(in_size);
          scan_nxt = '0;
          if ((n_act == '0) || (policy_r == pfa_pkg::POL_NONE)) begin
            state_nxt = ST_WRITE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_pend_nxt = 1'b1;
        scan_nxt    = scan_inc;
        if (scan_inc == n_act) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  // Scan payload: request size, address counter, and the tag of the read in flight.
  always_ff @(posedge clk) begin
    want_r   <= want_nxt;
    scan_r   <= scan_nxt;
    rd_idx_r <= rd_addr;
    rd_vld_r <= vld_r[rd_addr];
  end

  // Result register.
  always_comb begin
    out_vld_nxt = out_vld_r && !out_tready;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_alloc_r <= found;
      out_idx_r   <= found ? pfa_pkg::IN_IDX_W'(sel_idx) : '0;
      out_rem_r   <= found ? pfa_pkg::IN_SIZE_W'(rem) : '0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_alloc_r;
  assign out_tdata  = {4'b0000, out_rem_r, out_idx_r};

endmodule

// File: hdl/pfa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the partition free-space table. No dependencies.
module pfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/pfa_select.sv
// Shared compare unit: looks at one table entry per cycle while enabled and keeps the current pick.
// Depends on pfa_pkg for the policy codes and the control struct.
module pfa_select #(
  parameter int IDX_W     = 4,
  parameter int SIZE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pfa_pkg::sel_ctrl_t   ctrl,
  input  logic [SIZE_BITS-1:0] want,
  input  logic [SIZE_BITS-1:0] rd_val,
  input  logic [IDX_W-1:0]     rd_idx,
  output logic                 found,
  output logic [IDX_W-1:0]     sel_idx,
  output logic [SIZE_BITS-1:0] sel_val
);

  logic                 have_r, have_nxt;
  logic                 sel_fit_r;
  logic [IDX_W-1:0]     sel_idx_r;
  logic [SIZE_BITS-1:0] sel_val_r;
  logic                 fits, gt_sel, lt_sel, take;

  // Comparisons of the entry under test against the request and the current pick.
  assign fits   = (rd_val >= want);
  assign gt_sel = (rd_val > sel_val_r);
  assign lt_sel = (rd_val < sel_val_r);

  // Policy decides whether this entry replaces the current pick.
  always_comb begin
    unique case (ctrl.policy)
      pfa_pkg::POL_FIRST: take = !have_r && fits;
      pfa_pkg::POL_WORST: take = !have_r || gt_sel;
      pfa_pkg::POL_BEST:  take = fits && (!have_r || lt_sel);
      pfa_pkg::POL_NONE:  take = 1'b0;
      default:            take = 1'b0;
    endcase
  end

  always_comb begin
    have_nxt = have_r;
    if (ctrl.clear) begin
      have_nxt = 1'b0;
    end else if (ctrl.en && take) begin
      have_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else begin
      have_r <= have_nxt;
    end
  end

  // Pick payload; the fit flag matters for worst fit, which picks before checking size.
  always_ff @(posedge clk) begin
    if (!ctrl.clear && ctrl.en && take) begin
      sel_fit_r <= fits;
      sel_idx_r <= rd_idx;
      sel_val_r <= rd_val;
    end
  end

  assign found   = have_r && sel_fit_r;
  assign sel_idx = sel_idx_r;
  assign sel_val = sel_val_r;

endmodule

// File: hdl/pfa_checker.sv
// Port-level checks for the partition fit allocator, bound to the top level.
// Depends on pfa_pkg for widths and item kinds.
module pfa_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [pfa_pkg::TDATA_W-1:0]    in_tdata,
  input logic                           in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [pfa_pkg::TDATA_W-1:0]    out_tdata,
  input logic                           out_tuser
);

  // Leaving reset, nothing is pending and the input is open.
  a_reset_clean: assert property (@(posedge clk)
    $rose(rst_n) |-> (!out_tvalid && in_tready))
    else $error("block not idle after reset");

  // A load transaction never closes the input.
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == pfa_pkg::MODE_LOAD)) |=> in_tready)
    else $error("input closed after a load");

  // After a request transaction is taken, the input is closed.
  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == pfa_pkg::MODE_REQUEST)) |=> !in_tready)
    else $error("input open right after a request");

  // A refusal carries index zero and no remaining space.
  a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("refused result carries nonzero data");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind partition_fit_allocator pfa_checker u_pfa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
